[rtl/bfsmc_pkg.sv]
// bfsmc_pkg: shared types and constants of the breadth-first search block
// item and result payload structs, configuration register view, vertex color codes
// no dependencies
`timescale 1ns / 1ps

package bfsmc_pkg;

    localparam int VERTEX_W   = 6;
    localparam int COUNT_W    = 7;
    localparam int HITS_W     = 13;
    localparam int ROW_W      = 64;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [HITS_W-1:0] HITS_MAX = '1;

    // vertex colors
    localparam logic [1:0] COLOR_WHITE = 2'd0;
    localparam logic [1:0] COLOR_GRAY  = 2'd1;
    localparam logic [1:0] COLOR_BLACK = 2'd2;

    // item actions
    localparam logic ACTION_LOAD  = 1'b0;
    localparam logic ACTION_START = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_VERTEX_COUNT  = 1'b0;
    localparam logic REG_SOURCE_VERTEX = 1'b1;

    localparam logic [COUNT_W-1:0]  VERTEX_COUNT_RST  = 7'd64;
    localparam logic [VERTEX_W-1:0] SOURCE_VERTEX_RST = 6'd0;

    typedef struct packed {
        logic                action;
        logic [VERTEX_W-1:0] row_index;
        logic [ROW_W-1:0]    row_bits;
    } item_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] visited_vertex;
        logic [HITS_W-1:0]   cycle_hits;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  vertex_count;
        logic [VERTEX_W-1:0] source_vertex;
    } cfg_t;

endpackage

[rtl/bfsmc_ram.sv]
// bfsmc_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module bfsmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bfsmc_cfg.sv]
// bfsmc_cfg: apb register file holding vertex_count and source_vertex
// depends on bfsmc_pkg
`timescale 1ns / 1ps

module bfsmc_cfg
    import bfsmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [COUNT_W-1:0]  vertex_count_reg;
    logic [COUNT_W-1:0]  vertex_count_next;
    logic [VERTEX_W-1:0] source_vertex_reg;
    logic [VERTEX_W-1:0] source_vertex_next;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        vertex_count_next  = vertex_count_reg;
        source_vertex_next = source_vertex_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_VERTEX_COUNT:  vertex_count_next  = pwdata[COUNT_W-1:0];
                REG_SOURCE_VERTEX: source_vertex_next = pwdata[VERTEX_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg  <= VERTEX_COUNT_RST;
            source_vertex_reg <= SOURCE_VERTEX_RST;
        end
        else
        begin
            vertex_count_reg  <= vertex_count_next;
            source_vertex_reg <= source_vertex_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_VERTEX_COUNT:  prdata = PDATA_W'(vertex_count_reg);
            REG_SOURCE_VERTEX: prdata = PDATA_W'(source_vertex_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.vertex_count  = vertex_count_reg;
    assign cfg.source_vertex = source_vertex_reg;

endmodule

[rtl/bfs_matrix_cycle_count.sv]
// bfs_matrix_cycle_count: breadth-first search over an adjacency matrix, counting gray hits
// depends on bfsmc_pkg, bfsmc_ram, bfsmc_cfg
//
// usage: items arrive on item/item_valid/item_ready. a load item (action 0) writes one
// adjacency row and gives no result. a start item (action 1) runs the whole
// search from source_vertex over vertex_count vertices; item_ready stays low until the
// last result of that search has been placed in the output register.
// results leave on result/result_valid/result_ready, one transaction per visited vertex.
// per visited vertex: pop the queue and fetch the row, then scan the color ram (one read
// and up to one write a cycle, plus fill and drain), then mark the vertex black and place
// its result in the output register.
// the scan rate is set by the single read port of the color ram.
// if the receiver stalls, the search holds with its next result ready and resumes when
// the output register frees; loads are taken while the final result still waits.
// reset: all rows read as empty, colors white, registers at vertex_count 64, source 0.
// configuration goes through the apb port at byte addresses 0 and 4, pready always high.
`timescale 1ns / 1ps

module bfs_matrix_cycle_count
    import bfsmc_pkg::*;
#(
    parameter int VERTEX_MAX = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  item_t              item,
    input  logic               item_valid,
    output logic               item_ready,
    output result_t            result,
    output logic               result_valid,
    input  logic               result_ready,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int VW = $clog2(VERTEX_MAX);
    localparam int CW = $clog2(VERTEX_MAX + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEQ   = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_ROW   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    cfg_t cfg;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         head_reg, head_next;
    logic [CW-1:0]         tail_reg, tail_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [VW-1:0]         v_reg, v_next;
    logic [VERTEX_MAX-1:0] row_reg, row_next;
    logic [CW-1:0]         iss_reg, iss_next;
    logic                  pv_reg, pv_next;
    logic [VW-1:0]         pidx_reg, pidx_next;
    logic [HITS_W-1:0]     hits_reg, hits_next;
    logic [VERTEX_MAX-1:0] cvalid_reg, cvalid_next;
    logic [VERTEX_MAX-1:0] avalid_reg, avalid_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;

    logic                  adj_we;
    logic [VW-1:0]         adj_waddr;
    logic [VERTEX_MAX-1:0] adj_rdata;
    logic                  col_we;
    logic [VW-1:0]         col_waddr;
    logic [1:0]            col_wdata;
    logic [1:0]            col_rdata;
    logic                  q_we;
    logic [VW-1:0]         q_waddr;
    logic [VW-1:0]         q_wdata;
    logic [VW-1:0]         q_rdata;

    logic                  accept;
    logic [CW-1:0]         n_start;
    logic                  src_ok;
    logic [1:0]            color_eff;
    logic                  last_flag;

    bfsmc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // adjacency rows, read with the vertex coming out of the queue
    bfsmc_ram #(
        .WIDTH (VERTEX_MAX),
        .DEPTH (VERTEX_MAX)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (item.row_bits[VERTEX_MAX-1:0]),
        .raddr (q_rdata),
        .rdata (adj_rdata)
    );

    bfsmc_ram #(
        .WIDTH (2),
        .DEPTH (VERTEX_MAX)
    ) u_color_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (col_waddr),
        .wdata (col_wdata),
        .raddr (iss_reg[VW-1:0]),
        .rdata (col_rdata)
    );

    bfsmc_ram #(
        .WIDTH (VW),
        .DEPTH (VERTEX_MAX)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (head_reg[VW-1:0]),
        .rdata (q_rdata)
    );

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    assign n_start   = (cfg.vertex_count > COUNT_W'(VERTEX_MAX)) ? CW'(VERTEX_MAX)
                                                                 : CW'(cfg.vertex_count);
    assign src_ok    = (n_start != '0) && (COUNT_W'(cfg.source_vertex) < COUNT_W'(n_start));
    // entries not written since the start read as white
    assign color_eff = cvalid_reg[pidx_reg] ? col_rdata : COLOR_WHITE;
    assign last_flag = (head_reg >= tail_reg);

    assign adj_we    = accept && (item.action == ACTION_LOAD)
                       && (COUNT_W'(item.row_index) < COUNT_W'(VERTEX_MAX));
    assign adj_waddr = item.row_index[VW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        n_next         = n_reg;
        v_next         = v_reg;
        row_next       = row_reg;
        iss_next       = iss_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        hits_next      = hits_reg;
        cvalid_next    = cvalid_reg;
        avalid_next    = avalid_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        col_we         = 1'b0;
        col_waddr      = pidx_reg;
        col_wdata      = COLOR_GRAY;
        q_we           = 1'b0;
        q_waddr        = tail_reg[VW-1:0];
        q_wdata        = pidx_reg;

        if (adj_we)
        begin
            avalid_next[adj_waddr] = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.action == ACTION_START))
                begin
                    n_next      = n_start;
                    head_next   = '0;
                    tail_next   = '0;
                    hits_next   = '0;
                    cvalid_next = '0;
                    if (src_ok)
                    begin
                        col_we      = 1'b1;
                        col_waddr   = cfg.source_vertex[VW-1:0];
                        col_wdata   = COLOR_GRAY;
                        cvalid_next[cfg.source_vertex[VW-1:0]] = 1'b1;
                        // the queue restarts at entry zero
                        q_we        = 1'b1;
                        q_waddr     = '0;
                        q_wdata     = cfg.source_vertex[VW-1:0];
                        tail_next   = CW'(1);
                        state_next  = S_DEQ;
                    end
                end
            end
            S_DEQ:
            begin
                head_next  = head_reg + CW'(1);
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                v_next     = q_rdata;
                state_next = S_ROW;
            end
            S_ROW:
            begin
                row_next   = avalid_reg[v_reg] ? adj_rdata : '0;
                iss_next   = '0;
                pv_next    = 1'b0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // read color of the next neighbor while handling the one read last cycle
                if (iss_reg < n_reg)
                begin
                    pv_next   = 1'b1;
                    pidx_next = iss_reg[VW-1:0];
                    iss_next  = iss_reg + CW'(1);
                end
                else
                begin
                    pv_next = 1'b0;
                    if (!pv_reg)
                    begin
                        state_next = S_FIN;
                    end
                end
                if (pv_reg && row_reg[pidx_reg])
                begin
                    if (color_eff == COLOR_WHITE)
                    begin
                        col_we                = 1'b1;
                        col_wdata             = COLOR_GRAY;
                        cvalid_next[pidx_reg] = 1'b1;
                        q_we                  = 1'b1;
                        tail_next             = tail_reg + CW'(1);
                    end
                    else if (color_eff == COLOR_GRAY)
                    begin
                        if (hits_reg != HITS_MAX)
                        begin
                            hits_next = hits_reg + HITS_W'(1);
                        end
                    end
                end
            end
            S_FIN:
            begin
                col_we             = 1'b1;
                col_waddr          = v_reg;
                col_wdata          = COLOR_BLACK;
                cvalid_next[v_reg] = 1'b1;
                state_next         = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_next.visited_vertex = VERTEX_W'(v_reg);
                    out_next.cycle_hits     = hits_reg;
                    out_next.last           = last_flag;
                    state_next              = last_flag ? S_IDLE : S_DEQ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            n_reg         <= '0;
            iss_reg       <= '0;
            pv_reg        <= 1'b0;
            hits_reg      <= '0;
            cvalid_reg    <= '0;
            avalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            n_reg         <= n_next;
            iss_reg       <= iss_next;
            pv_reg        <= pv_next;
            hits_reg      <= hits_next;
            cvalid_reg    <= cvalid_next;
            avalid_reg    <= avalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        row_reg  <= row_next;
        pidx_reg <= pidx_next;
        out_reg  <= out_next;
    end

endmodule

[tb/tb_bfs_matrix_cycle_count.sv]
// tb_bfs_matrix_cycle_count: self-checking bench for the adjacency-matrix bfs block
// predicts visit order and gray-hit counts per search, compares each result transaction
// depends on bfsmc_pkg and bfs_matrix_cycle_count
`timescale 1ns / 1ps

module tb_bfs_matrix_cycle_count;
    import bfsmc_pkg::*;

    localparam int VERTEX_MAX    = 64;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 5000000;

    localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT  = {REG_VERTEX_COUNT, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SOURCE_VERTEX = {REG_SOURCE_VERTEX, 2'b00};

    logic               clk;
    logic               rst_n;
    item_t              item;
    logic               item_valid;
    logic               item_ready;
    result_t            result;
    logic               result_valid;
    logic               result_ready;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // predictor state
    logic [ROW_W-1:0]    adj_rows [VERTEX_MAX];
    logic [COUNT_W-1:0]  cfg_vertex_count;
    logic [VERTEX_W-1:0] cfg_source;

    item_t   pending_items[$];
    result_t expected_visits[$];
    result_t oldest_visit;

    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  item_fire;
    int  cycle_count;
    int  error_count;
    int  items_accepted;
    int  searches_accepted;
    int  visits_checked;
    int  settings_written;

    bfs_matrix_cycle_count #(
        .VERTEX_MAX(VERTEX_MAX)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 clk = ~clk;

    // one full search from the configured source, queued as expected visits
    function automatic void walk_search();
        int                  n;
        int                  head;
        int                  tail;
        int                  i;
        int                  visits;
        logic [VERTEX_W-1:0] v;
        logic [ROW_W-1:0]    bits;
        logic [HITS_W-1:0]   hits;
        logic [VERTEX_W-1:0] order [VERTEX_MAX];
        logic [1:0]          color [VERTEX_MAX];
        result_t             r;
        n = (cfg_vertex_count > VERTEX_MAX) ? VERTEX_MAX : int'(cfg_vertex_count);
        for (i = 0; i < VERTEX_MAX; i++)
            color[i] = COLOR_WHITE;
        head = 0;
        tail = 0;
        hits = '0;
        visits = 0;
        if (n == 0 || cfg_source >= n)
            return;
        color[cfg_source] = COLOR_GRAY;
        order[0] = cfg_source;
        tail = 1;
        while (head < tail && visits < VERTEX_MAX)
        begin
            v = order[head];
            bits = adj_rows[v];
            head++;
            for (i = 0; i < n; i++)
            begin
                if (bits[i])
                begin
                    if (color[i] == COLOR_WHITE)
                    begin
                        color[i] = COLOR_GRAY;
                        if (tail < VERTEX_MAX)
                        begin
                            order[tail] = VERTEX_W'(i);
                            tail++;
                        end
                    end
                    else if (color[i] == COLOR_GRAY && hits != HITS_MAX)
                    begin
                        hits++;
                    end
                end
            end
            color[v] = COLOR_BLACK;
            r.visited_vertex = v;
            r.cycle_hits = hits;
            r.last = (head >= tail);
            expected_visits.push_back(r);
            visits++;
        end
    endfunction

    function automatic item_t make_item(logic act, logic [VERTEX_W-1:0] row,
                                        logic [ROW_W-1:0] bits);
        item_t it;
        it.action = act;
        it.row_index = row;
        it.row_bits = bits;
        return it;
    endfunction

    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: r = r & {$urandom, $urandom};
            1: r = r & {$urandom, $urandom} & {$urandom, $urandom};
            2: r = ROW_W'(1) << $urandom_range(0, ROW_W - 1);
            3: r = r | {$urandom, $urandom};
            default: ;
        endcase
        return r;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || item_valid || expected_visits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // upper data bits are random, only the register width is kept
    task automatic configure(input logic [COUNT_W-1:0] count, input logic [VERTEX_W-1:0] src);
        wait_idle();
        write_reg(ADDR_VERTEX_COUNT, ($urandom & ~32'h7F) | PDATA_W'(count));
        write_reg(ADDR_SOURCE_VERTEX, ($urandom & ~32'h3F) | PDATA_W'(src));
        cfg_vertex_count = count;
        cfg_source = src;
        settings_written++;
    endtask

    task automatic run_rounds(input int quota, input int tx_pct, input int rx_pct);
        int pushed;
        int roll;
        int n;
        int nmax;
        int loads;
        int starts;
        int k;
        logic [VERTEX_W-1:0] src;
        logic [VERTEX_W-1:0] row;
        pushed = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (pushed < quota)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                n = VERTEX_MAX;
            else if (roll < 12)
                n = $urandom_range(VERTEX_MAX + 1, 127);
            else if (roll < 15)
                n = 0;
            else
                n = $urandom_range(1, 12);
            nmax = (n > VERTEX_MAX) ? VERTEX_MAX : n;
            if (nmax == 0 || $urandom_range(0, 9) == 0)
                src = VERTEX_W'($urandom_range(0, VERTEX_MAX - 1));
            else
                src = VERTEX_W'($urandom_range(0, nmax - 1));
            configure(COUNT_W'(n), src);
            loads = (nmax == 0) ? 1 : $urandom_range(1, (nmax < 10) ? nmax : 10);
            for (k = 0; k < loads; k++)
            begin
                // mostly rows in use, some noise rows beyond the vertex count
                if (nmax == 0 || $urandom_range(0, 9) == 0)
                    row = VERTEX_W'($urandom_range(0, VERTEX_MAX - 1));
                else
                    row = VERTEX_W'($urandom_range(0, nmax - 1));
                pending_items.push_back(make_item(ACTION_LOAD, row, random_row()));
            end
            starts = $urandom_range(1, 2);
            for (k = 0; k < starts; k++)
                pending_items.push_back(make_item(ACTION_START,
                                                  VERTEX_W'($urandom_range(0, 63)),
                                                  {$urandom, $urandom}));
            pushed += loads + starts;
        end
    endtask

    // driver: new transaction only once the previous one has been taken
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_fire))
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
        result_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        item_fire = item_valid && item_ready;
        if (item_fire)
        begin
            items_accepted++;
            if (item.action == ACTION_LOAD)
            begin
                adj_rows[item.row_index] = item.row_bits;
            end
            else
            begin
                searches_accepted++;
                walk_search();
            end
        end
        if (result_valid && result_ready)
        begin
            if (expected_visits.size() == 0)
            begin
                $error("unexpected result transaction: visited_vertex %0d cycle_hits %0d last %0b",
                       result.visited_vertex, result.cycle_hits, result.last);
                error_count++;
            end
            else
            begin
                oldest_visit = expected_visits.pop_front();
                visits_checked++;
                if (result.visited_vertex !== oldest_visit.visited_vertex)
                begin
                    $error("visited_vertex: expected %0d, actual %0d",
                           oldest_visit.visited_vertex, result.visited_vertex);
                    error_count++;
                end
                if (result.cycle_hits !== oldest_visit.cycle_hits)
                begin
                    $error("cycle_hits: expected %0d, actual %0d",
                           oldest_visit.cycle_hits, result.cycle_hits);
                    error_count++;
                end
                if (result.last !== oldest_visit.last)
                begin
                    $error("last: expected %0b, actual %0b", oldest_visit.last, result.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        item = '0;
        item_valid = 1'b0;
        result_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_fire = 1'b0;
        cycle_count = 0;
        error_count = 0;
        items_accepted = 0;
        searches_accepted = 0;
        visits_checked = 0;
        settings_written = 0;
        tx_idle_pct = 30;
        rx_idle_pct = 77;
        for (int i = 0; i < VERTEX_MAX; i++)
            adj_rows[i] = '0;
        cfg_vertex_count = VERTEX_COUNT_RST;
        cfg_source = SOURCE_VERTEX_RST;

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty matrix at reset settings: a lone source vertex
        pending_items.push_back(make_item(ACTION_START, 6'd0, '0));
        // source reaches everything, self loops at both ends
        pending_items.push_back(make_item(ACTION_LOAD, 6'd0, '1));
        pending_items.push_back(make_item(ACTION_LOAD, 6'd63, 64'h8000_0000_0000_0001));
        pending_items.push_back(make_item(ACTION_START, 6'd63, '1));

        // single vertex with a self loop, upper row bits ignored
        configure(7'd1, 6'd0);
        pending_items.push_back(make_item(ACTION_START, 6'd0, '0));
        // zero vertices: nothing to visit
        configure(7'd0, 6'd0);
        pending_items.push_back(make_item(ACTION_START, 6'd0, '0));
        // count above the maximum saturates, source at the top vertex
        configure(7'd127, 6'd63);
        pending_items.push_back(make_item(ACTION_START, 6'd0, '0));
        // source outside the vertices in use
        configure(7'd10, 6'd12);
        pending_items.push_back(make_item(ACTION_LOAD, 6'd12, 64'h0000_0000_0000_03FF));
        pending_items.push_back(make_item(ACTION_START, 6'd0, '0));
        // five-vertex ring closing back on the source, with stray bits past the count
        configure(7'd5, 6'd4);
        pending_items.push_back(make_item(ACTION_LOAD, 6'd0, 64'hFFFF_FFFF_FFFF_FFE2));
        pending_items.push_back(make_item(ACTION_LOAD, 6'd1, 64'h4));
        pending_items.push_back(make_item(ACTION_LOAD, 6'd2, 64'h8));
        pending_items.push_back(make_item(ACTION_LOAD, 6'd3, 64'h10));
        pending_items.push_back(make_item(ACTION_LOAD, 6'd4, 64'h11));
        pending_items.push_back(make_item(ACTION_START, 6'd0, '0));
        pending_items.push_back(make_item(ACTION_START, 6'd0, '0));
        // two vertices pointing at each other
        configure(7'd2, 6'd1);
        pending_items.push_back(make_item(ACTION_LOAD, 6'd1, 64'h1));
        pending_items.push_back(make_item(ACTION_LOAD, 6'd0, 64'h2));
        pending_items.push_back(make_item(ACTION_START, 6'd0, '0));

        run_rounds(53, 30, 77);
        run_rounds(53, 77, 30);
        run_rounds(53, 0, 0);

        wait_idle();
        $display("covered %0d transactions in, %0d of them searches, over %0d register settings",
                 items_accepted, searches_accepted, settings_written);
        $display("compared %0d visit results in visit order", visits_checked);
        if (error_count == 0 && expected_visits.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
